// ===== hw/rtl/ese_pkg.sv =====
// ----------------------------------------------------------------------------
// ese_pkg
// Shared constants, payload types and character helpers for the escape
// sequence expander.
// ----------------------------------------------------------------------------
package ese_pkg;

  localparam int CHAR_W       = 8;
  localparam int LEN_W        = 12;
  localparam int CAP_W        = 13;
  localparam int SLOTS        = 4;
  localparam int MAX_CAP_DEF  = 4096;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;
  localparam int QCNT_W       = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd256;

  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_X      = 8'h78;
  localparam logic [CHAR_W-1:0] CH_R      = 8'h72;
  localparam logic [CHAR_W-1:0] CH_N      = 8'h6E;
  localparam logic [CHAR_W-1:0] CH_T      = 8'h74;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A_LO   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_F_LO   = 8'h66;
  localparam logic [CHAR_W-1:0] CH_A_UP   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_F_UP   = 8'h46;

  // one accepted character worth of output: up to four bytes plus an end item
  typedef struct packed {
    logic [SLOTS-1:0][CHAR_W-1:0] bytes;
    logic [SLOTS-1:0]             mask;
    logic                         is_end;
    logic [LEN_W-1:0]             len;
  } ese_entry_t;

  function automatic logic hex_ok(input logic [CHAR_W-1:0] ch);
    return ch inside {[CH_0:CH_9], [CH_A_LO:CH_F_LO], [CH_A_UP:CH_F_UP]};
  endfunction

  function automatic logic [3:0] hex_val(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] d;
    if (ch inside {[CH_0:CH_9]}) begin
      d = ch - CH_0;
    end else if (ch inside {[CH_A_LO:CH_F_LO]}) begin
      d = ch - CH_A_LO + 8'd10;
    end else begin
      d = ch - CH_A_UP + 8'd10;
    end
    return d[3:0];
  endfunction

endpackage

// ===== hw/rtl/ese_if.sv =====
// ----------------------------------------------------------------------------
// ese_if
// Valid/ready channels for source characters and expanded bytes.
// ----------------------------------------------------------------------------
interface ese_in_if import ese_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;

  modport source (output valid, in_char, in_last, input ready);
  modport sink   (input valid, in_char, in_last, output ready);
endinterface

interface ese_out_if import ese_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_byte;
  logic              out_is_end;
  logic [LEN_W-1:0]  out_length;

  modport source (output valid, out_byte, out_is_end, out_length, input ready);
  modport sink   (input valid, out_byte, out_is_end, out_length, output ready);
endinterface

// ===== hw/rtl/ese_front.sv =====
// ----------------------------------------------------------------------------
// ese_front
// Accepts source characters, tracks the escape parse state and byte count,
// and turns each character into at most one queue entry of bytes to write.
// ----------------------------------------------------------------------------
module ese_front import ese_pkg::*; #(
  parameter int MAX_CAPACITY = MAX_CAP_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  ese_in_if.sink           char_in,
  input  logic             q_full,
  output logic             push,
  output ese_entry_t       entry
);

  localparam int LW = $clog2(MAX_CAPACITY);
  localparam int CW = $clog2(MAX_CAPACITY + 1);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [1:0] {
    M_PLAIN,
    M_ESC,
    M_HEX1,
    M_HEX2
  } mode_t;

  function automatic logic [LW-1:0] limit_of(input logic [CAP_W-1:0] c);
    logic [XW-1:0] cx;
    cx = XW'(c);
    if (c == '0) begin
      return '0;
    end else if (cx >= XW'(MAX_CAPACITY)) begin
      return LW'(MAX_CAPACITY - 1);
    end else begin
      return LW'(cx - XW'(1));
    end
  endfunction

  mode_t             mode;
  mode_t             mode_next;
  mode_t             mode_go;
  logic [CHAR_W-1:0] held;
  logic [LW-1:0]     wc;
  logic [LW-1:0]     wc_next;
  logic [LW-1:0]     lim;

  logic                         acc;
  logic [CHAR_W-1:0]            ch;
  logic                         last;
  logic [SLOTS-1:0][CHAR_W-1:0] cand_byte;
  logic [SLOTS-1:0]             cand_on;
  logic [SLOTS-1:0]             cand_need2;
  logic                         esc_req;
  logic                         held_load;
  logic [SLOTS-1:0]             emit;
  logic [LW-1:0]                diff;
  logic [LW+2:0]                diffx;
  logic [2:0]                   av0;
  logic [2:0]                   av;
  logic                         go_esc;
  logic [2:0]                   cnt;
  logic [LW+2:0]                wc_sum;

  assign ch            = char_in.in_char;
  assign last          = char_in.in_last;
  assign char_in.ready = !q_full;
  assign acc           = char_in.valid && !q_full;

  // room left below the byte limit, capped at the most one character can use
  always_comb begin
    diff  = (wc < lim) ? (lim - wc) : '0;
    diffx = {3'b000, diff};
    av0   = (diffx > (LW+3)'(SLOTS)) ? 3'(SLOTS) : diffx[2:0];
  end

  always_comb begin
    cand_byte  = '0;
    cand_on    = '0;
    cand_need2 = '0;
    esc_req    = 1'b0;
    held_load  = 1'b0;
    mode_go    = M_PLAIN;
    case (mode)
      M_PLAIN: begin
        if (ch == CH_BSLASH && !last) begin
          esc_req = 1'b1;
        end else begin
          cand_on[0]   = 1'b1;
          cand_byte[0] = ch;
        end
      end
      M_ESC: begin
        cand_on[0] = 1'b1;
        if (ch == CH_R) begin
          cand_byte[0] = CH_CR;
        end else if (ch == CH_N) begin
          cand_byte[0] = CH_LF;
        end else if (ch == CH_T) begin
          cand_byte[0] = CH_TAB;
        end else if (ch == CH_BSLASH) begin
          cand_byte[0] = CH_BSLASH;
        end else if (ch == CH_X && !last) begin
          cand_on[0] = 1'b0;
          mode_go    = M_HEX1;
        end else if (ch == CH_X) begin
          // \x cut off by end of string
          cand_byte[0]  = CH_BSLASH;
          cand_on[1]    = 1'b1;
          cand_byte[1]  = CH_X;
          cand_need2[1] = 1'b1;
        end else begin
          cand_byte[0] = CH_BSLASH;
          cand_on[1]   = 1'b1;
          cand_byte[1] = ch;
        end
      end
      M_HEX1: begin
        if (hex_ok(ch) && !last) begin
          held_load = 1'b1;
          mode_go   = M_HEX2;
        end else begin
          cand_on[0]    = 1'b1;
          cand_byte[0]  = CH_BSLASH;
          cand_on[1]    = 1'b1;
          cand_byte[1]  = CH_X;
          cand_need2[1] = 1'b1;
          if (ch == CH_BSLASH && !last) begin
            esc_req = 1'b1;
          end else begin
            cand_on[2]   = 1'b1;
            cand_byte[2] = ch;
          end
        end
      end
      M_HEX2: begin
        cand_on[0] = 1'b1;
        if (hex_ok(ch)) begin
          cand_byte[0] = {hex_val(held), hex_val(ch)};
        end else begin
          // bad second digit: literal \x, the held digit, then ch as plain
          cand_byte[0]  = CH_BSLASH;
          cand_on[1]    = 1'b1;
          cand_byte[1]  = CH_X;
          cand_need2[1] = 1'b1;
          cand_on[2]    = 1'b1;
          cand_byte[2]  = held;
          if (ch == CH_BSLASH && !last) begin
            esc_req = 1'b1;
          end else begin
            cand_on[3]   = 1'b1;
            cand_byte[3] = ch;
          end
        end
      end
      default: begin
        cand_on = '0;
      end
    endcase
  end

  // walk the candidates in order against the remaining room
  always_comb begin
    av   = av0;
    emit = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (cand_on[i] && (cand_need2[i] ? (av >= 3'd2) : (av >= 3'd1))) begin
        emit[i] = 1'b1;
        av      = av - 3'd1;
      end
    end
    go_esc = esc_req && (av >= 3'd1);
    cnt    = {2'b00, emit[0]} + {2'b00, emit[1]} + {2'b00, emit[2]} + {2'b00, emit[3]};
    wc_sum = {3'b000, wc} + (LW+3)'(cnt);
  end

  always_comb begin
    if (last) begin
      mode_next = M_PLAIN;
      wc_next   = '0;
    end else begin
      mode_next = go_esc ? M_ESC : mode_go;
      wc_next   = LW'(wc_sum);
    end
  end

  assign push         = acc && ((emit != '0) || last);
  assign entry.bytes  = cand_byte;
  assign entry.mask   = emit;
  assign entry.is_end = last;
  assign entry.len    = LEN_W'(wc_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_PLAIN;
      wc   <= '0;
      held <= '0;
      lim  <= limit_of(CAP_RESET);
    end else begin
      if (cfg_we) begin
        lim <= limit_of(cfg_wdata);
      end
      if (acc) begin
        mode <= mode_next;
        wc   <= wc_next;
        if (held_load) begin
          held <= ch;
        end
      end
    end
  end

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    acc && last |=> mode == M_PLAIN && wc == '0)
    else $error("parse state not cleared after end of string");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    acc && !last && !cfg_we && wc <= lim |=> wc <= lim)
    else $error("byte count passed the limit");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("entry pushed into a full queue");

endmodule

// ===== hw/rtl/ese_queue.sv =====
// ----------------------------------------------------------------------------
// ese_queue
// Small register queue of expansion entries between front and back.
// ----------------------------------------------------------------------------
module ese_queue import ese_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  ese_entry_t wr_entry,
  input  logic       pop,
  output ese_entry_t head,
  output logic       full,
  output logic       not_empty
);

  ese_entry_t        store [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from an empty queue");

endmodule

// ===== hw/rtl/ese_back.sv =====
// ----------------------------------------------------------------------------
// ese_back
// Takes queue entries and sends their bytes, then the end item of a final
// entry, one beat per cycle while byte_out.ready is high.
// ----------------------------------------------------------------------------
module ese_back import ese_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  ese_entry_t head,
  input  logic       q_valid,
  output logic       pop,
  ese_out_if.source  byte_out
);

  ese_entry_t             cur;
  logic                   cur_valid;
  logic [SLOTS-1:0]       mask_rest;
  logic [$clog2(SLOTS)-1:0] sel;
  logic                   last_beat;
  logic                   taken;
  logic                   load;

  // lowest pending byte goes first
  always_comb begin
    sel = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (cur.mask[i]) begin
        sel = ($clog2(SLOTS))'(i);
      end
    end
  end

  assign mask_rest = cur.mask & (cur.mask - SLOTS'(1));
  assign last_beat = (cur.mask == '0) || ((mask_rest == '0) && !cur.is_end);
  assign taken     = cur_valid && byte_out.ready;
  assign load      = !cur_valid || (taken && last_beat);
  assign pop       = load && q_valid;

  assign byte_out.valid      = cur_valid;
  assign byte_out.out_is_end = (cur.mask == '0);
  assign byte_out.out_byte   = (cur.mask == '0) ? '0 : cur.bytes[sel];
  assign byte_out.out_length = (cur.mask == '0) ? cur.len : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (load) begin
      cur_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (q_valid) begin
        cur <= head;
      end
    end else if (taken) begin
      cur.mask <= mask_rest;
    end
  end

  a_cur_nonempty: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.mask != '0) || cur.is_end)
    else $error("held entry has nothing to send");

endmodule

// ===== hw/rtl/escape_sequence_expander_unit.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_expander_unit
// Backslash escape expander with a byte limit and an end-of-string item.
// ----------------------------------------------------------------------------
// Usage:
//   char_in carries one source character per beat, in_last set on the final
//   character of a string. byte_out carries expanded bytes and, after the
//   final character, an end item (out_is_end set) with the byte count.
//   cfg_we/cfg_wdata write the capacity; write it only between strings.
// Timing:
//   An accepted character becomes at most one queue entry in the same cycle;
//   its beats then pass through the queue and the back stage's held entry
//   before they appear on byte_out. The output side sends one beat per
//   cycle while byte_out.ready is high, so the input takes one character per
//   cycle as long as each causes at most one beat; a character that yields
//   several beats (up to five) holds the output until all are taken, and a
//   four-entry queue absorbs such bursts.
// Reset:
//   parse state and byte count clear, capacity returns to 256, queue empties.
// Stall:
//   with byte_out.ready low the current beat holds, the queue fills, and
//   char_in.ready drops once the queue is full.
// ----------------------------------------------------------------------------
module escape_sequence_expander_unit import ese_pkg::*; #(
  parameter int MAX_CAPACITY = MAX_CAP_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  ese_in_if.sink           char_in,
  ese_out_if.source        byte_out
);

  ese_entry_t wr_entry;
  ese_entry_t head;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_valid;

  ese_front #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .char_in   (char_in),
    .q_full    (q_full),
    .push      (push),
    .entry     (wr_entry)
  );

  ese_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_entry  (wr_entry),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .not_empty (q_valid)
  );

  ese_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_valid  (q_valid),
    .pop      (pop),
    .byte_out (byte_out)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for escape_sequence_expander_unit. Source strings are
// built from escape sequences with random content and sent through the
// character channel. An in-bench model of the expansion predicts every output
// beat, and each beat on the byte channel is compared field by field.
// Capacity changes between runs, the sender and receiver pause at random, and
// a long receiver hold lets the output queue fill up.
// ----------------------------------------------------------------------------
module tb;
  import ese_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 160;
  localparam int SETTLE       = 6;

  typedef enum logic [1:0] {PM_PLAIN, PM_ESC, PM_HEX1, PM_HEX2} parse_mode_e;

  typedef struct packed {
    logic [CHAR_W-1:0] data;
    logic              is_end;
    logic [LEN_W-1:0]  len;
  } out_beat_t;

  class expansion_checker;
    logic [CAP_W-1:0] capacity;
    parse_mode_e      mode;
    logic [CHAR_W-1:0] held;
    int unsigned      written;
    int               beats_this_char;
    out_beat_t        expected_beats[$];
    int               errors;

    function new();
      capacity = CAP_RESET;
      mode     = PM_PLAIN;
      held     = '0;
      written  = 0;
      errors   = 0;
    endfunction

    function int unsigned usable();
      return (capacity > MAX_CAP_DEF) ? MAX_CAP_DEF : capacity;
    endfunction

    function int unsigned byte_limit();
      return (usable() == 0) ? 0 : usable() - 1;
    endfunction

    function bit is_hex(logic [CHAR_W-1:0] ch);
      return (ch >= CH_0 && ch <= CH_9) || (ch >= CH_A_LO && ch <= CH_F_LO) ||
             (ch >= CH_A_UP && ch <= CH_F_UP);
    endfunction

    function logic [3:0] nibble(logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] v;
      if (ch >= CH_0 && ch <= CH_9) begin
        v = ch - CH_0;
      end else if (ch >= CH_A_LO && ch <= CH_F_LO) begin
        v = ch - CH_A_LO + 8'd10;
      end else begin
        v = ch - CH_A_UP + 8'd10;
      end
      return v[3:0];
    endfunction

    function void push_beat(logic [CHAR_W-1:0] b, logic e, int unsigned len);
      out_beat_t nb;
      if (beats_this_char < 5) begin
        nb.data   = b;
        nb.is_end = e;
        nb.len    = len[LEN_W-1:0];
        expected_beats.push_back(nb);
      end
      beats_this_char++;
    endfunction

    function void put_byte(logic [CHAR_W-1:0] b);
      if (written < byte_limit()) begin
        push_beat(b, 1'b0, 0);
        written++;
      end
    endfunction

    function void plain(logic [CHAR_W-1:0] ch, bit last);
      if (written >= byte_limit()) return;
      if (ch == CH_BSLASH && !last) mode = PM_ESC;
      else put_byte(ch);
    endfunction

    // backslash always, the x only while two more bytes still fit
    function void bad_hex();
      put_byte(CH_BSLASH);
      if (written + 2 < usable()) put_byte(CH_X);
    endfunction

    function void accept_char(logic [CHAR_W-1:0] ch, logic last);
      parse_mode_e cur;
      int unsigned room;
      logic [CHAR_W-1:0] h;
      cur = mode;
      beats_this_char = 0;
      mode = PM_PLAIN;
      case (cur)
        PM_PLAIN: begin
          plain(ch, last);
        end
        PM_ESC: begin
          if (ch == CH_R) put_byte(CH_CR);
          else if (ch == CH_N) put_byte(CH_LF);
          else if (ch == CH_T) put_byte(CH_TAB);
          else if (ch == CH_BSLASH) put_byte(CH_BSLASH);
          else if (ch == CH_X) begin
            if (last) bad_hex();
            else mode = PM_HEX1;
          end else begin
            room = written + 2;
            put_byte(CH_BSLASH);
            if (room < usable()) put_byte(ch);
          end
        end
        PM_HEX1: begin
          if (is_hex(ch) && !last) begin
            held = ch;
            mode = PM_HEX2;
          end else begin
            bad_hex();
            plain(ch, last);
          end
        end
        default: begin
          if (is_hex(held) && is_hex(ch)) begin
            put_byte({nibble(held), nibble(ch)});
          end else begin
            h = held;
            bad_hex();
            plain(h, 1'b0);
            mode = PM_PLAIN;
            plain(ch, last);
          end
          held = '0;
        end
      endcase
      if (last) begin
        push_beat('0, 1'b1, written);
        mode    = PM_PLAIN;
        held    = '0;
        written = 0;
      end
    endfunction

    function void check_beat(logic [CHAR_W-1:0] b, logic e, logic [LEN_W-1:0] len);
      out_beat_t exp_beat;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: byte %h end %b len %0d", b, e, len);
        return;
      end
      exp_beat = expected_beats.pop_front();
      if (exp_beat.data !== b || exp_beat.is_end !== e || exp_beat.len !== len) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected byte %h end %b len %0d, got byte %h end %b len %0d",
                   exp_beat.data, exp_beat.is_end, exp_beat.len, b, e, len);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  ese_in_if  char_in_if ();
  ese_out_if byte_out_if ();

  escape_sequence_expander_unit #(
    .MAX_CAPACITY (MAX_CAP_DEF)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .char_in   (char_in_if),
    .byte_out  (byte_out_if)
  );

  expansion_checker sb;
  int src_pct;
  int snk_pct;
  int hold_seq;
  int cycle_cnt = 0;
  logic [CHAR_W-1:0] src_text[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: checks beats and drives ready, with the long hold counted here
  initial begin
    int hold_left;
    int seen_seq;
    hold_left = 0;
    seen_seq  = 0;
    byte_out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && byte_out_if.valid && byte_out_if.ready)
        sb.check_beat(byte_out_if.out_byte, byte_out_if.out_is_end,
                      byte_out_if.out_length);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        byte_out_if.ready <= 1'b0;
      end else begin
        byte_out_if.ready <= ($urandom_range(99) >= snk_pct);
      end
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
    while ($urandom_range(99) < src_pct) begin
      char_in_if.valid <= 1'b0;
      @(posedge clk);
    end
    char_in_if.valid   <= 1'b1;
    char_in_if.in_char <= ch;
    char_in_if.in_last <= last;
    do @(posedge clk); while (!char_in_if.ready);
    sb.accept_char(ch, last);
  endtask

  task automatic send_text(input bit close);
    foreach (src_text[i]) send_char(src_text[i], close && (i == src_text.size() - 1));
  endtask

  function automatic logic [CHAR_W-1:0] hex_digit();
    int r;
    r = $urandom_range(21);
    if (r < 10) return CH_0 + 8'(r);
    if (r < 16) return CH_A_LO + 8'(r - 10);
    return CH_A_UP + 8'(r - 16);
  endfunction

  // mostly well-formed escapes with random content, some noise
  task automatic gen_text(input int ntok);
    int r;
    src_text.delete();
    repeat (ntok) begin
      r = $urandom_range(99);
      if (r < 40) begin
        src_text.push_back(8'($urandom_range(255)));
      end else if (r < 50) begin
        src_text.push_back(CH_BSLASH);
        case ($urandom_range(3))
          0: src_text.push_back(CH_R);
          1: src_text.push_back(CH_N);
          2: src_text.push_back(CH_T);
          default: src_text.push_back(CH_BSLASH);
        endcase
      end else if (r < 65) begin
        src_text.push_back(CH_BSLASH);
        src_text.push_back(CH_X);
        src_text.push_back(hex_digit());
        src_text.push_back(hex_digit());
      end else if (r < 73) begin
        src_text.push_back(CH_BSLASH);
        src_text.push_back(8'($urandom_range(255)));
      end else if (r < 81) begin
        src_text.push_back(CH_BSLASH);
        src_text.push_back(CH_X);
        src_text.push_back(8'($urandom_range(255)));
      end else if (r < 89) begin
        src_text.push_back(CH_BSLASH);
        src_text.push_back(CH_X);
        src_text.push_back(hex_digit());
        src_text.push_back(8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(1, 3)) src_text.push_back(8'($urandom_range(255)));
      end
    end
    // sometimes the string ends inside an escape
    case ($urandom_range(9))
      0: src_text.push_back(CH_BSLASH);
      1: begin
        src_text.push_back(CH_BSLASH);
        src_text.push_back(CH_X);
      end
      2: begin
        src_text.push_back(CH_BSLASH);
        src_text.push_back(CH_X);
        src_text.push_back(hex_digit());
      end
      default: ;
    endcase
  endtask

  task automatic quiesce();
    char_in_if.valid <= 1'b0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.capacity = v;
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int src, input int snk,
                           input int nstr, input int maxtok);
    quiesce();
    write_capacity(cap);
    src_pct = src;
    snk_pct = snk;
    repeat (nstr) begin
      gen_text($urandom_range(1, maxtok));
      send_text(1'b1);
    end
  endtask

  initial begin
    sb = new();
    src_pct   = 0;
    snk_pct   = 0;
    hold_seq  = 0;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    char_in_if.valid    <= 1'b0;
    char_in_if.in_char  <= '0;
    char_in_if.in_last  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // simple escapes, zero byte and top byte at reset capacity
    src_text = '{CH_BSLASH, CH_R, CH_BSLASH, CH_N, CH_BSLASH, CH_T, CH_BSLASH, CH_BSLASH,
                 8'h00, 8'hFF};
    send_text(1'b1);
    // hex in both cases, unknown escape, bad second digit, \x as last char
    src_text = '{CH_BSLASH, CH_X, "4", "1", CH_BSLASH, CH_X, "A", "f", CH_BSLASH, "q",
                 CH_BSLASH, CH_X, "4", "z", CH_BSLASH, CH_X};
    send_text(1'b1);
    // lone backslash as the whole string
    src_text = '{CH_BSLASH};
    send_text(1'b1);
    // string ends after one hex digit
    src_text = '{CH_BSLASH, CH_X, "7"};
    send_text(1'b1);

    run_phase(13'h1FFF, 0, 0, 3, 8);
    run_phase(13'd0, 52, 0, 4, 3);
    run_phase(13'd1, 0, 52, 4, 3);
    run_phase(13'd2, 23, 23, 6, 3);
    run_phase(13'd3, 0, 0, 6, 4);
    run_phase(13'd4, 52, 0, 6, 4);
    run_phase(13'd5, 0, 52, 6, 4);
    run_phase(13'($urandom_range(6, 12)), 23, 23, 8, 5);
    run_phase(13'd4096, 0, 0, 4, 8);
    run_phase(13'($urandom_range(1, 4096)), 52, 52, 3, 6);

    // capacity lowered below the running count in the middle of a string
    run_phase(13'd256, 0, 0, 0, 1);
    src_text = '{"a", "b", "c", "d", "e", "f"};
    send_text(1'b0);
    quiesce();
    write_capacity(13'd3);
    src_text = '{"g", CH_BSLASH, CH_N, "h"};
    send_text(1'b1);

    // long receiver hold while the sender keeps going
    run_phase(13'd256, 0, 0, 0, 1);
    hold_seq++;
    gen_text(30);
    send_text(1'b1);

    quiesce();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
